FILE: rtl/gts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gts_pkg
// Shared types and codes for the grid turtle with its position stack.
// ----------------------------------------------------------------------------
package gts_pkg;

    // Default depth of the saved-state stack
    localparam int STACK_DEPTH_DEF = 16;

    // Command codes
    localparam logic [2:0] FUNC_FORWARD = 3'd0;
    localparam logic [2:0] FUNC_LEFT    = 3'd1;
    localparam logic [2:0] FUNC_RIGHT   = 3'd2;
    localparam logic [2:0] FUNC_PUSH    = 3'd3;
    localparam logic [2:0] FUNC_POP     = 3'd4;
    localparam logic [2:0] FUNC_LOAD    = 3'd5;

    // Headings
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Reset position
    localparam logic [15:0] POS_RESET = 16'hFFFF;

    // Turtle state, also one stack entry
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [1:0]  heading;
    } t_turtle_state;

    // Command item
    typedef struct packed {
        logic [2:0]         func;
        logic signed [15:0] load_x;
        logic signed [15:0] load_y;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [1:0]         heading;
        logic               drawn;
        logic [1:0]         status;
    } t_out_item;

endpackage : gts_pkg
`default_nettype wire

FILE: rtl/gts_stack_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gts_stack_ram
// Saved-state stack storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gts_stack_ram
    import gts_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_turtle_state i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output t_turtle_state      o_rdata
);

    t_turtle_state r_mem [STACK_DEPTH];
    t_turtle_state r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : gts_stack_ram
`default_nettype wire

FILE: rtl/grid_turtle_with_state_stack_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_turtle_with_state_stack_core
// Grid turtle: steps, turns, loads, and pushes/pops its state on a stack.
// ----------------------------------------------------------------------------
// Stages: execute register, then output register. Throughput: one command
// per cycle unless the result channel stalls; the stack RAM read is issued
// at accept and feeds the execute-stage update, so pops pipeline freely.
// Reset: position -1,-1, heading left, stack empty; the stack RAM is not
// cleared (entries are only read after being pushed).
// ----------------------------------------------------------------------------
module grid_turtle_with_state_stack_core
    import gts_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    // command channel
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    // result channel
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Accept stage signals
    logic          in_acc;
    logic          push_ok;
    logic          pop_ok;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [1:0]    acc_status;

    // Execute stage registers
    logic          r_s1_valid;
    logic [2:0]    r_s1_func;
    logic [15:0]   r_s1_load_x;
    logic [15:0]   r_s1_load_y;
    logic [AW-1:0] r_s1_addr;
    logic          r_s1_ok;
    logic [1:0]    r_s1_status;
    logic          s1_adv;
    logic          s1_fire;

    // Turtle state and forwarding of the last stack write
    t_turtle_state r_turtle;
    t_turtle_state n_turtle;
    t_turtle_state ram_rdata;
    t_turtle_state pop_data;
    t_turtle_state r_fwd_data;
    logic [AW-1:0] r_fwd_addr;
    logic          ram_we;
    logic          n_drawn;

    // Output register
    logic          r_out_valid;
    t_out_item     r_out_item;

    // Handshake: execute stage moves when the output register can take an item
    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && s1_adv;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Stack bookkeeping at accept
    assign push_ok = (i_in_item.func == FUNC_PUSH) && (r_count != CW'(STACK_DEPTH));
    assign pop_ok  = (i_in_item.func == FUNC_POP) && (r_count != '0);
    assign cnt_m1  = r_count - CW'(1);

    always_comb begin
        n_count    = r_count;
        acc_status = STATUS_OK;
        if (i_in_item.func == FUNC_PUSH) begin
            if (push_ok) begin
                n_count = r_count + CW'(1);
            end else begin
                acc_status = STATUS_FULL;
            end
        end else if (i_in_item.func == FUNC_POP) begin
            if (pop_ok) begin
                n_count = cnt_m1;
            end else begin
                acc_status = STATUS_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count <= n_count;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Execute stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_func   <= i_in_item.func;
            r_s1_load_x <= i_in_item.load_x;
            r_s1_load_y <= i_in_item.load_y;
            r_s1_addr   <= (i_in_item.func == FUNC_POP) ? cnt_m1[AW-1:0] : r_count[AW-1:0];
            r_s1_ok     <= push_ok || pop_ok;
            r_s1_status <= acc_status;
        end
    end

    // Stack memory
    assign ram_we = s1_fire && (r_s1_func == FUNC_PUSH) && r_s1_ok;

    gts_stack_ram #(
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (r_turtle),
        .i_re    (in_acc && pop_ok),
        .i_raddr (cnt_m1[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Last write kept to cover a pop read issued while a push writes the same entry
    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= r_turtle;
        end
    end

    assign pop_data = (r_fwd_addr == r_s1_addr) ? r_fwd_data : ram_rdata;

    // Turtle update
    always_comb begin
        n_turtle = r_turtle;
        n_drawn  = 1'b0;
        unique case (r_s1_func)
            FUNC_FORWARD: begin
                n_drawn = 1'b1;
                unique case (r_turtle.heading)
                    DIR_LEFT:  n_turtle.x = r_turtle.x - 16'd1;
                    DIR_RIGHT: n_turtle.x = r_turtle.x + 16'd1;
                    DIR_DOWN:  n_turtle.y = r_turtle.y - 16'd1;
                    DIR_UP:    n_turtle.y = r_turtle.y + 16'd1;
                endcase
            end
            FUNC_LEFT:  n_turtle.heading = r_turtle.heading + 2'd3;
            FUNC_RIGHT: n_turtle.heading = r_turtle.heading + 2'd1;
            FUNC_PUSH:  n_turtle = r_turtle;
            FUNC_POP: begin
                if (r_s1_ok) begin
                    n_turtle = pop_data;
                end
            end
            FUNC_LOAD: begin
                n_turtle.x       = r_s1_load_x;
                n_turtle.y       = r_s1_load_y;
                n_turtle.heading = DIR_RIGHT;
            end
            default: n_turtle = r_turtle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turtle.x       <= POS_RESET;
            r_turtle.y       <= POS_RESET;
            r_turtle.heading <= DIR_LEFT;
        end else if (s1_fire) begin
            r_turtle <= n_turtle;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_item.pos_x   <= n_turtle.x;
            r_out_item.pos_y   <= n_turtle.y;
            r_out_item.heading <= n_turtle.heading;
            r_out_item.drawn   <= n_drawn;
            r_out_item.status  <= r_s1_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule : grid_turtle_with_state_stack_core
`default_nettype wire

FILE: tb/sv/turtle_track_checker.sv
// ----------------------------------------------------------------------------
// turtle_track_checker
// Watches the command and result channels of the grid turtle. It keeps its
// own turtle state and position stack, predicts each result in command
// order, and compares every returned result field by field.
// ----------------------------------------------------------------------------
module turtle_track_checker
    import gts_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire logic i_cmd_stall,
    input  t_in_item  i_cmd_item,
    input  wire logic i_res_valid,
    input  wire logic i_res_stall,
    input  t_out_item i_res_item,
    output int        o_mismatches,
    output int        o_outstanding
);

    localparam int REPORT_LIMIT = 10;

    // Predicted turtle state
    logic [15:0]   turtle_x;
    logic [15:0]   turtle_y;
    logic [1:0]    turtle_dir;
    t_turtle_state saved_states [STACK_DEPTH];
    int            saved_count;

    t_out_item expected_results [$];
    int        mismatches = 0;

    // Apply one command to the predicted state and return its result
    function automatic t_out_item advance_turtle(t_in_item cmd);
        t_out_item res;
        res.drawn  = 1'b0;
        res.status = STATUS_OK;
        case (cmd.func)
            FUNC_FORWARD: begin
                case (turtle_dir)
                    DIR_LEFT:  turtle_x = turtle_x - 16'd1;
                    DIR_RIGHT: turtle_x = turtle_x + 16'd1;
                    DIR_DOWN:  turtle_y = turtle_y - 16'd1;
                    default:   turtle_y = turtle_y + 16'd1;
                endcase
                res.drawn = 1'b1;
            end
            FUNC_LEFT:  turtle_dir = turtle_dir - 2'd1;
            FUNC_RIGHT: turtle_dir = turtle_dir + 2'd1;
            FUNC_PUSH: begin
                if (saved_count >= STACK_DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    saved_states[saved_count] = {turtle_x, turtle_y, turtle_dir};
                    saved_count++;
                end
            end
            FUNC_POP: begin
                if (saved_count == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    saved_count--;
                    turtle_x   = saved_states[saved_count].x;
                    turtle_y   = saved_states[saved_count].y;
                    turtle_dir = saved_states[saved_count].heading;
                end
            end
            FUNC_LOAD: begin
                turtle_x   = cmd.load_x;
                turtle_y   = cmd.load_y;
                turtle_dir = DIR_RIGHT;
            end
            default: ; // unused codes leave everything as is
        endcase
        res.pos_x   = turtle_x;
        res.pos_y   = turtle_y;
        res.heading = turtle_dir;
        return res;
    endfunction

    // Track accepted items on both channels
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item predicted;
        if (!i_rst_n) begin
            turtle_x    = POS_RESET;
            turtle_y    = POS_RESET;
            turtle_dir  = DIR_LEFT;
            saved_count = 0;
            expected_results.delete();
        end else begin
            if (i_cmd_valid && !i_cmd_stall) begin
                predicted = advance_turtle(i_cmd_item);
                expected_results.insert(expected_results.size(), predicted);
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("checker: result with none pending: x=%h y=%h dir=%0d",
                                 i_res_item.pos_x, i_res_item.pos_y, i_res_item.heading);
                        $display("checker:          drawn=%0d st=%0d",
                                 i_res_item.drawn, i_res_item.status);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (i_res_item.pos_x !== want.pos_x || i_res_item.pos_y !== want.pos_y
                            || i_res_item.heading !== want.heading
                            || i_res_item.drawn !== want.drawn
                            || i_res_item.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("checker: mismatch exp x=%h y=%h dir=%0d drawn=%0d st=%0d",
                                     want.pos_x, want.pos_y, want.heading,
                                     want.drawn, want.status);
                            $display("checker:          got x=%h y=%h dir=%0d drawn=%0d st=%0d",
                                     i_res_item.pos_x, i_res_item.pos_y, i_res_item.heading,
                                     i_res_item.drawn, i_res_item.status);
                        end
                    end
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_results.size();
    end

endmodule : turtle_track_checker

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives turtle commands into the grid turtle core: a directed walk over
// the headings, coordinate wrap, loads and stack edges, then random command
// bursts that fill and drain the stack. Sender gaps and receiver stalls vary
// by phase; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import gts_pkg::*;

    localparam int ITEMS        = 1150;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_GAP      = 20;

    // Command codes the block treats as no-ops
    localparam logic [2:0] FUNC_UNUSED_A = 3'd6;
    localparam logic [2:0] FUNC_UNUSED_B = 3'd7;

    // Random burst flavors
    localparam int MODE_GROW   = 0;
    localparam int MODE_UNWIND = 1;
    localparam int MODE_WANDER = 2;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    t_in_item  cmd_item  = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    t_out_item res_item;

    int send_idle_pct = 11;
    int stall_pct     = 47;
    int quiet_cycles  = 0;
    int mismatches;
    int outstanding;

    always #2 clk = ~clk;

    grid_turtle_with_state_stack_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (cmd_valid),
        .o_in_stall  (cmd_stall),
        .i_in_item   (cmd_item),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out_item  (res_item)
    );

    turtle_track_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd_stall   (cmd_stall),
        .i_cmd_item    (cmd_item),
        .i_res_valid   (res_valid),
        .i_res_stall   (res_stall),
        .i_res_item    (res_item),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Receiver back-pressure
    always @(posedge clk) begin
        res_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: too long without any handshake
    always @(posedge clk) begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_item make_cmd(logic [2:0] f, logic [15:0] lx, logic [15:0] ly);
        t_in_item cmd;
        cmd.func   = f;
        cmd.load_x = lx;
        cmd.load_y = ly;
        return cmd;
    endfunction

    // Mostly uniform, sometimes a wrap boundary
    function automatic logic [15:0] pick_coord();
        logic [15:0] c;
        c = 16'($urandom);
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0:       c = 16'h7FFF;
                1:       c = 16'h8000;
                2:       c = 16'h0000;
                default: c = 16'hFFFF;
            endcase
        end
        return c;
    endfunction

    // One random command; the burst mode tilts push against pop
    function automatic t_in_item random_cmd(int mode);
        int          roll;
        int          push_w;
        int          pop_w;
        logic [2:0]  f;
        roll   = $urandom_range(99);
        push_w = (mode == MODE_GROW) ? 35 : (mode == MODE_UNWIND) ? 8 : 12;
        pop_w  = (mode == MODE_UNWIND) ? 35 : (mode == MODE_GROW) ? 8 : 12;
        if (roll < 5) begin
            f = $urandom_range(1) ? FUNC_UNUSED_A : FUNC_UNUSED_B;
        end else if (roll < 12) begin
            f = FUNC_LOAD;
        end else if (roll < 12 + push_w) begin
            f = FUNC_PUSH;
        end else if (roll < 12 + push_w + pop_w) begin
            f = FUNC_POP;
        end else begin
            case ($urandom_range(3))
                0, 1:    f = FUNC_FORWARD;
                2:       f = FUNC_LEFT;
                default: f = FUNC_RIGHT;
            endcase
        end
        return make_cmd(f, pick_coord(), pick_coord());
    endfunction

    // Present one item, with an optional gap first, and wait for its handshake
    task automatic send_cmd(input t_in_item item);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < MAX_GAP) gap++;
        if (gap != 0) begin
            cmd_valid <= 1'b0;
            cmd_item  <= make_cmd(3'($urandom_range(7)), 16'($urandom), 16'($urandom));
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= item;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
    endtask

    initial begin
        int random_items;
        int mode;
        random_items = ITEMS - 26;
        mode = MODE_WANDER;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed walk: reset state, every heading, wraps, stack edges
        send_cmd(make_cmd(FUNC_UNUSED_A, 16'h1234, 16'h5678)); // shows reset state
        send_cmd(make_cmd(FUNC_POP, '0, '0));                  // pop on empty stack
        send_cmd(make_cmd(FUNC_FORWARD, '0, '0));              // heading left
        send_cmd(make_cmd(FUNC_RIGHT, '0, '0));
        send_cmd(make_cmd(FUNC_FORWARD, '0, '0));              // heading up
        send_cmd(make_cmd(FUNC_RIGHT, '0, '0));
        send_cmd(make_cmd(FUNC_FORWARD, '0, '0));              // heading right
        send_cmd(make_cmd(FUNC_RIGHT, '0, '0));
        send_cmd(make_cmd(FUNC_FORWARD, '0, '0));              // heading down
        send_cmd(make_cmd(FUNC_RIGHT, '0, '0));                // down wraps to left
        send_cmd(make_cmd(FUNC_LEFT, '0, '0));                 // left wraps to down
        send_cmd(make_cmd(FUNC_UNUSED_B, 16'hFFFF, 16'hFFFF));
        send_cmd(make_cmd(FUNC_LOAD, 16'h7FFF, 16'h7FFF));     // heading forced right
        send_cmd(make_cmd(FUNC_FORWARD, '0, '0));              // x wraps to most negative
        send_cmd(make_cmd(FUNC_LEFT, '0, '0));
        send_cmd(make_cmd(FUNC_FORWARD, '0, '0));              // y wraps to most negative
        send_cmd(make_cmd(FUNC_PUSH, '0, '0));
        send_cmd(make_cmd(FUNC_LOAD, 16'h8000, 16'h8000));
        send_cmd(make_cmd(FUNC_LEFT, '0, '0));
        send_cmd(make_cmd(FUNC_LEFT, '0, '0));
        send_cmd(make_cmd(FUNC_FORWARD, '0, '0));              // x wraps to most positive
        send_cmd(make_cmd(FUNC_LEFT, '0, '0));
        send_cmd(make_cmd(FUNC_FORWARD, '0, '0));              // y wraps to most positive
        send_cmd(make_cmd(FUNC_POP, '0, '0));                  // restores pushed state
        send_cmd(make_cmd(FUNC_LOAD, 16'h0000, 16'hFFFF));
        send_cmd(make_cmd(FUNC_POP, '0, '0));                  // empty again

        // Random bursts; idling swaps sides, then stops
        for (int i = 0; i < random_items; i++) begin
            if (i == random_items / 3) begin
                send_idle_pct = 47;
                stall_pct <= 11;
            end
            if (i == 2 * random_items / 3) begin
                send_idle_pct = 0;
                stall_pct <= 0;
            end
            if (i % 32 == 0) mode = $urandom_range(2);
            send_cmd(random_cmd(mode));
        end
        cmd_valid <= 1'b0;

        // Drain outstanding results, then a short tail
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule : testbench
